@@ rtl/two_of_five_code_line_codec_defines.svh @@
// Assertion macros used by the bound checker module.
`ifndef TWO_OF_FIVE_CODE_LINE_CODEC_DEFINES_SVH
`define TWO_OF_FIVE_CODE_LINE_CODEC_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TOFC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tofc check failed");

// Next-cycle implication, disabled while reset is high.
`define TOFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tofc check failed");

`endif

@@ rtl/tofc_pkg.sv @@
package tofc_pkg;

   localparam int CH_W       = 8;
   localparam int CODE_W     = 25;
   localparam int BCD_W      = 20;
   localparam int STATUS_W   = 2;
   localparam int RSP_DATA_W = 48;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0] ZERO_SUM = 4'd11;

   typedef enum logic [1:0] {
      KIND_DIGIT,
      KIND_SPACE,
      KIND_OTHER,
      KIND_END
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [3:0]     digit;
   } token_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ENCODED = 2'd0,
      STATUS_DECODED = 2'd1,
      STATUS_ERROR   = 2'd2
   } status_type;

   // Two-of-five pattern of a decimal digit, weights 7,4,2,1,0 from the top.
   function automatic logic [4:0] tof_pattern(input logic [3:0] d);
      logic [4:0] p;
      case (d)
         4'd0:    p = 5'b11000;
         4'd1:    p = 5'b00011;
         4'd2:    p = 5'b00101;
         4'd3:    p = 5'b00110;
         4'd4:    p = 5'b01001;
         4'd5:    p = 5'b01010;
         4'd6:    p = 5'b01100;
         4'd7:    p = 5'b10001;
         4'd8:    p = 5'b10010;
         4'd9:    p = 5'b10100;
         default: p = 5'b00000;
      endcase
      return p;
   endfunction

   // Weight of a bit position within a group of five.
   function automatic logic [3:0] tof_weight(input logic [2:0] pos);
      logic [3:0] w;
      case (pos)
         3'd0:    w = 4'd7;
         3'd1:    w = 4'd4;
         3'd2:    w = 4'd2;
         3'd3:    w = 4'd1;
         default: w = 4'd0;
      endcase
      return w;
   endfunction

endpackage

@@ rtl/tofc_front.sv @@
module tofc_front (
   input  logic [tofc_pkg::CH_W-1:0] ch,
   input  logic                      ends_line,
   output tofc_pkg::token_type       token
);

   // Sort each character into digit, space, other or terminator.
   always_comb begin
      token.digit = ch[3:0];
      if (ends_line) begin
         token.kind = tofc_pkg::KIND_END;
      end else if (ch inside {[8'h30:8'h39]}) begin
         token.kind = tofc_pkg::KIND_DIGIT;
      end else if (ch == 8'h20) begin
         token.kind = tofc_pkg::KIND_SPACE;
      end else begin
         token.kind = tofc_pkg::KIND_OTHER;
      end
   end

endmodule

@@ rtl/tofc_queue.sv @@
module tofc_queue #(
   parameter int DEPTH = tofc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tofc_pkg::token_type push_token,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output tofc_pkg::token_type head_token
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tofc_pkg::token_type slots_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_token = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

@@ rtl/tofc_back.sv @@
module tofc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  tofc_pkg::token_type             head_token,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tofc_pkg::status_type            rsp_status,
   output logic [tofc_pkg::CODE_W-1:0]     rsp_code,
   output logic [tofc_pkg::BCD_W-1:0]      rsp_bcd
);

   logic [2:0]  run_length_ff, run_length_in;
   logic [4:0]  digit_count_ff, digit_count_in;
   logic        format_error_ff, format_error_in;
   logic        nonbinary_ff, nonbinary_in;
   logic        group_error_ff, group_error_in;
   logic [1:0]  group_ones_ff, group_ones_in;
   logic [3:0]  group_sum_ff, group_sum_in;
   logic [2:0]  group_pos_ff, group_pos_in;
   logic [tofc_pkg::CODE_W-1:0] code_accum_ff, code_accum_in;
   logic [tofc_pkg::BCD_W-1:0]  decoded_ff, decoded_in;

   logic                        out_valid_ff, out_valid_in;
   tofc_pkg::status_type        out_status_ff, out_status_in;
   logic [tofc_pkg::CODE_W-1:0] out_code_ff, out_code_in;
   logic [tofc_pkg::BCD_W-1:0]  out_bcd_ff, out_bcd_in;

   logic       out_free;
   logic [1:0] ones_step;
   logic [3:0] sum_step;
   logic       run_bad;
   logic       end_error;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign pop        = head_valid && ((head_token.kind != tofc_pkg::KIND_END) || out_free);
   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_code   = out_code_ff;
   assign rsp_bcd    = out_bcd_ff;
   assign run_bad    = (run_length_ff != 3'd0) && (run_length_ff != 3'd5);
   assign end_error  = format_error_ff || run_bad;

   always_comb begin
      run_length_in   = run_length_ff;
      digit_count_in  = digit_count_ff;
      format_error_in = format_error_ff;
      nonbinary_in    = nonbinary_ff;
      group_error_in  = group_error_ff;
      group_ones_in   = group_ones_ff;
      group_sum_in    = group_sum_ff;
      group_pos_in    = group_pos_ff;
      code_accum_in   = code_accum_ff;
      decoded_in      = decoded_ff;
      out_valid_in    = out_valid_ff && !rsp_ready;
      out_status_in   = out_status_ff;
      out_code_in     = out_code_ff;
      out_bcd_in      = out_bcd_ff;
      ones_step       = group_ones_ff;
      sum_step        = group_sum_ff;

      if (pop) begin
         case (head_token.kind)
            tofc_pkg::KIND_DIGIT: begin
               if (run_length_ff >= 3'd5) begin
                  format_error_in = 1'b1;
               end else begin
                  run_length_in = run_length_ff + 3'd1;
               end
               if (digit_count_ff < 5'd5) begin
                  code_accum_in = {code_accum_ff[tofc_pkg::CODE_W-6:0],
                                   tofc_pkg::tof_pattern(head_token.digit)};
               end
               if (digit_count_ff < 5'd25) begin
                  if (head_token.digit > 4'd1) begin
                     nonbinary_in = 1'b1;
                  end else if (head_token.digit == 4'd1) begin
                     if (group_ones_ff >= 2'd2) begin
                        group_error_in = 1'b1;
                     end else begin
                        ones_step = group_ones_ff + 2'd1;
                        sum_step  = group_sum_ff + tofc_pkg::tof_weight(group_pos_ff);
                     end
                  end
                  group_ones_in = ones_step;
                  group_sum_in  = sum_step;
                  group_pos_in  = group_pos_ff + 3'd1;
                  // Close the group: two ones required, sum 11 stands for zero.
                  if (group_pos_ff == 3'd4) begin
                     if (ones_step < 2'd2) begin
                        group_error_in = 1'b1;
                     end
                     decoded_in = {decoded_ff[tofc_pkg::BCD_W-5:0],
                                   (sum_step == tofc_pkg::ZERO_SUM) ? 4'd0 : sum_step};
                     group_ones_in = 2'd0;
                     group_sum_in  = 4'd0;
                     group_pos_in  = 3'd0;
                  end
               end
               if (digit_count_ff != 5'd31) begin
                  digit_count_in = digit_count_ff + 5'd1;
               end
            end
            tofc_pkg::KIND_SPACE, tofc_pkg::KIND_OTHER: begin
               if (run_bad || (head_token.kind == tofc_pkg::KIND_OTHER)) begin
                  format_error_in = 1'b1;
               end
               run_length_in = 3'd0;
            end
            tofc_pkg::KIND_END: begin
               out_valid_in  = 1'b1;
               out_status_in = tofc_pkg::STATUS_ERROR;
               out_code_in   = '0;
               out_bcd_in    = '0;
               if (!end_error && (digit_count_ff == 5'd5)) begin
                  out_status_in = tofc_pkg::STATUS_ENCODED;
                  out_code_in   = code_accum_ff;
               end else if (!end_error && (digit_count_ff == 5'd25) &&
                            !nonbinary_ff && !group_error_ff) begin
                  out_status_in = tofc_pkg::STATUS_DECODED;
                  out_bcd_in    = decoded_ff;
               end
               run_length_in   = '0;
               digit_count_in  = '0;
               format_error_in = 1'b0;
               nonbinary_in    = 1'b0;
               group_error_in  = 1'b0;
               group_ones_in   = '0;
               group_sum_in    = '0;
               group_pos_in    = '0;
               code_accum_in   = '0;
               decoded_in      = '0;
            end
            default: begin
               run_length_in = run_length_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_length_ff   <= '0;
         digit_count_ff  <= '0;
         format_error_ff <= 1'b0;
         nonbinary_ff    <= 1'b0;
         group_error_ff  <= 1'b0;
         group_ones_ff   <= '0;
         group_sum_ff    <= '0;
         group_pos_ff    <= '0;
         code_accum_ff   <= '0;
         decoded_ff      <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         run_length_ff   <= run_length_in;
         digit_count_ff  <= digit_count_in;
         format_error_ff <= format_error_in;
         nonbinary_ff    <= nonbinary_in;
         group_error_ff  <= group_error_in;
         group_ones_ff   <= group_ones_in;
         group_sum_ff    <= group_sum_in;
         group_pos_ff    <= group_pos_in;
         code_accum_ff   <= code_accum_in;
         decoded_ff      <= decoded_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_code_ff   <= out_code_in;
      out_bcd_ff    <= out_bcd_in;
   end

endmodule

@@ rtl/two_of_five_code_line_codec.sv @@
// Channel   Direction  Ports                       Carries
// req       in         req_tvalid/tready/tdata/tlast  one character, tlast = terminator
// rsp       out        rsp_tvalid/tready/tdata/tuser  one result per line, tuser = status
//
// Takes one item per cycle unless the queue is full; the character queue between classifier and
// state update lets the input keep flowing while a result waits.
// A result is registered in the output stage when its terminator leaves the queue.
// Reset is synchronous, active high, and clears all line state.
// A stalled result holds the next terminator, and the items behind it, at the head of the queue;
// characters ahead of that terminator keep draining into the line state while rsp_tready is low.
module two_of_five_code_line_codec #(
   parameter int QUEUE_DEPTH = tofc_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tofc_pkg::CH_W-1:0]           req_tdata,  // [7:0] ch
   input  logic                                req_tlast,  // ends_line
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tofc_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [24:0] code_bits, [44:25] bcd_digits
   output logic [tofc_pkg::STATUS_W-1:0]       rsp_tuser   // [1:0] status
);

   tofc_pkg::token_type   front_token;
   tofc_pkg::token_type   head_token;
   tofc_pkg::status_type  status;
   logic                  queue_full;
   logic                  head_valid;
   logic                  pop;
   logic [tofc_pkg::CODE_W-1:0] code_bits;
   logic [tofc_pkg::BCD_W-1:0]  bcd_digits;

   assign req_tready = !queue_full;

   // Classify the incoming character.
   tofc_front u_front (
      .ch        (req_tdata),
      .ends_line (req_tlast),
      .token     (front_token)
   );

   // Hold classified items until the line state takes them.
   tofc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid && req_tready),
      .push_token (front_token),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_token (head_token)
   );

   // Advance the line state and register the result.
   tofc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_token (head_token),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (status),
      .rsp_code   (code_bits),
      .rsp_bcd    (bcd_digits)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = {{(tofc_pkg::RSP_DATA_W - tofc_pkg::CODE_W - tofc_pkg::BCD_W){1'b0}},
                       bcd_digits, code_bits};

endmodule

@@ rtl/tofc_checker.sv @@
`include "two_of_five_code_line_codec_defines.svh"

module tofc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tofc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [tofc_pkg::STATUS_W-1:0]   rsp_tuser
);

   `TOFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   `TOFC_ASSERT_SAME(a_error_zero, clock, reset, rsp_tvalid && (rsp_tuser == tofc_pkg::STATUS_ERROR), rsp_tdata == '0)

   `TOFC_ASSERT_SAME(a_encoded_no_bcd, clock, reset, rsp_tvalid && (rsp_tuser == tofc_pkg::STATUS_ENCODED), rsp_tdata[44:25] == '0)

   `TOFC_ASSERT_SAME(a_decoded_no_code, clock, reset, rsp_tvalid && (rsp_tuser == tofc_pkg::STATUS_DECODED), rsp_tdata[24:0] == '0)

endmodule

bind two_of_five_code_line_codec tofc_checker u_tofc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ sim/two_of_five_code_line_codec_checker.sv @@
module two_of_five_code_line_codec_checker
   import tofc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [CH_W-1:0]       req_tdata,  // [7:0] ch
   input  logic                  req_tlast,  // ends_line
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // [24:0] code_bits, [44:25] bcd_digits
   input  logic [STATUS_W-1:0]   rsp_tuser,  // [1:0] status
   output int                    fail_count,
   output int                    pending_lines,
   output int                    lines_checked
);

   typedef struct packed {
      status_type          status;
      logic [CODE_W-1:0]   code;
      logic [BCD_W-1:0]    bcd;
   } line_result_t;

   line_result_t line_results_q[$];

   // Line state of the predictor.
   logic [2:0]        run_len;
   logic [4:0]        digits_seen;
   logic              bad_format;
   logic              saw_nonbinary;
   logic              bad_group;
   logic [1:0]        ones_in_group;
   logic [3:0]        weight_sum;
   logic [CODE_W-1:0] code_shift;
   logic [BCD_W-1:0]  bcd_shift;

   // Weights 7,4,2,1,0 from the top bit of a group down.
   function automatic logic [3:0] bit_weight(input int pos);
      return (pos == 0) ? 4'd7 : 4'(8 >> pos);
   endfunction

   // Build the code of a digit from the one pair of weights that sums to it modulo 11.
   function automatic logic [4:0] digit_code(input logic [3:0] d);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 4; i++)
         for (int j = i + 1; j < 5; j++)
            if ((bit_weight(i) + bit_weight(j)) % 11 == d)
               p = (5'b10000 >> i) | (5'b10000 >> j);
      return p;
   endfunction

   task automatic clear_line();
      run_len       = '0;
      digits_seen   = '0;
      bad_format    = 1'b0;
      saw_nonbinary = 1'b0;
      bad_group     = 1'b0;
      ones_in_group = '0;
      weight_sum    = '0;
      code_shift    = '0;
      bcd_shift     = '0;
   endtask

   task automatic end_run();
      if (run_len != 3'd0 && run_len != 3'd5)
         bad_format = 1'b1;
      run_len = '0;
   endtask

   task automatic take_char(input logic [7:0] c);
      logic [3:0] d;
      int         pos;
      if (c >= "0" && c <= "9") begin
         d = 4'(c - "0");
         if (run_len >= 3'd5)
            bad_format = 1'b1;
         else
            run_len++;
         if (digits_seen < 5'd5)
            code_shift = {code_shift[CODE_W-6:0], digit_code(d)};
         if (digits_seen < 5'd25) begin
            pos = digits_seen % 5;
            if (d > 4'd1) begin
               saw_nonbinary = 1'b1;
            end else if (d == 4'd1) begin
               // a third one flags the group and adds no weight
               if (ones_in_group >= 2'd2) begin
                  bad_group = 1'b1;
               end else begin
                  ones_in_group++;
                  weight_sum += bit_weight(pos);
               end
            end
            if (pos == 4) begin
               if (ones_in_group < 2'd2)
                  bad_group = 1'b1;
               bcd_shift     = {bcd_shift[BCD_W-5:0], (weight_sum == 4'd11) ? 4'd0 : weight_sum};
               ones_in_group = '0;
               weight_sum    = '0;
            end
         end
         if (digits_seen < 5'd31)
            digits_seen++;
      end else begin
         end_run();
         if (c != " ")
            bad_format = 1'b1;
      end
   endtask

   task automatic finish_line(output line_result_t r);
      end_run();
      r = '{status: STATUS_ERROR, code: '0, bcd: '0};
      if (!bad_format) begin
         if (digits_seen == 5'd5) begin
            r.status = STATUS_ENCODED;
            r.code   = code_shift;
         end else if (digits_seen == 5'd25 && !saw_nonbinary && !bad_group) begin
            r.status = STATUS_DECODED;
            r.bcd    = bcd_shift;
         end
      end
      clear_line();
   endtask

   always @(posedge clock) begin
      line_result_t want;
      line_result_t got;
      if (reset) begin
         clear_line();
         line_results_q.delete();
      end else begin
         // compare first: a result at this edge always belongs to an older line
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser);
            got.code   = rsp_tdata[CODE_W-1:0];
            got.bcd    = rsp_tdata[CODE_W+BCD_W-1:CODE_W];
            if (line_results_q.size() == 0) begin
               $display("%0t: unexpected result status %0d code %h bcd %h",
                        $time, got.status, got.code, got.bcd);
               fail_count <= fail_count + 1;
            end else begin
               want = line_results_q.pop_front();
               if (got.status != want.status)
                  $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
               if (got.code != want.code)
                  $display("%0t: code_bits expected %h, got %h", $time, want.code, got.code);
               if (got.bcd != want.bcd)
                  $display("%0t: bcd_digits expected %h, got %h", $time, want.bcd, got.bcd);
               if (got != want)
                  fail_count <= fail_count + 1;
               lines_checked <= lines_checked + 1;
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tlast) begin
               finish_line(want);
               line_results_q.push_back(want);
            end else begin
               take_char(req_tdata);
            end
         end
      end
      pending_lines <= line_results_q.size();
   end

endmodule

@@ sim/two_of_five_code_line_codec_tb.sv @@
module two_of_five_code_line_codec_tb;
   import tofc_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CH_W-1:0]       req_tdata = '0;       // [7:0] ch
   logic                  req_tlast = 1'b0;     // ends_line
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;            // [24:0] code_bits, [44:25] bcd_digits
   logic [STATUS_W-1:0]   rsp_tuser;            // [1:0] status

   int fail_count;
   int pending_lines;
   int lines_checked;

   // Percent of cycles in which each side holds off.
   int req_idle_pct = 37;
   int rsp_idle_pct = 37;

   int items_sent  = 0;
   int enc_lines   = 0;
   int dec_lines   = 0;
   int other_lines = 0;

   // Characters of the line being built, terminator not included.
   logic [7:0] line_chars[$];

   two_of_five_code_line_codec i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   two_of_five_code_line_codec_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_lines (pending_lines),
      .lines_checked (lines_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: stall at random, held low through reset.
   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Present one item, idling at random first, and hold it until accepted.
   // Here valid is only lowered inside the idle loop, so it never drops and
   // rises in the same time step.
   task automatic send_item(input logic [7:0] c, input logic last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
   endtask

   // Send the built line, then a terminator whose character field is noise.
   task automatic send_line();
      foreach (line_chars[k])
         send_item(line_chars[k], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
      line_chars.delete();
   endtask

   // Hold the sender until every line result has come back. The extra edge
   // lets the checker register the last terminator first.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_lines != 0)
         @(posedge clock);
   endtask

   task automatic add_spaces(input int max_n);
      repeat ($urandom_range(0, max_n))
         line_chars.push_back(" ");
   endtask

   task automatic add_digits(input int n);
      repeat (n)
         line_chars.push_back(8'("0" + $urandom_range(0, 9)));
   endtask

   // Bail out if the run hangs.
   initial begin
      #2_000_000;
      $display("[two_of_five_code_line_codec] ERROR");
      $finish;
   end

   initial begin
      logic [24:0] bits;
      int          odd_pos;
      int          pos_a;
      int          pos_b;
      int          runs;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines: empty, a clean encode, short and long digit runs,
      // and the extreme character codes.
      send_line();
      line_chars = '{"0", "9", "8", "7", "6"};
      send_line();
      line_chars = '{" ", "1", "2", "3", "4", " "};
      send_line();
      line_chars = '{8'hFF, 8'h00};
      send_line();
      line_chars = '{"1", "2", "3", "4", "5", "6"};
      send_line();
      other_lines += 4;
      enc_lines++;
      drain_results();

      while (items_sent < 1000) begin
         // one long stretch with no idling on either side
         req_idle_pct = (items_sent >= 400 && items_sent < 650) ? 0 : 37;
         rsp_idle_pct = req_idle_pct;

         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: begin
               // five digits to encode, up to two spaces on each side
               add_spaces(2);
               add_digits(5);
               add_spaces(2);
               enc_lines++;
            end
            5, 6, 7, 8, 9, 10, 11: begin
               // 25 binary digits, each group a legal two-of-five pattern
               for (int g = 0; g < 5; g++) begin
                  pos_a = $urandom_range(0, 4);
                  pos_b = $urandom_range(0, 3);
                  if (pos_b >= pos_a)
                     pos_b++;
                  for (int b = 0; b < 5; b++)
                     bits[24 - 5 * g - b] = (b == pos_a || b == pos_b);
               end
               // sometimes break a group, or drop in a digit that is not binary
               if ($urandom_range(0, 3) == 0)
                  bits[$urandom_range(0, 24)] ^= 1'b1;
               odd_pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : -1;
               add_spaces(1);
               for (int k = 0; k < 25; k++) begin
                  if (k == odd_pos)
                     line_chars.push_back(8'("2" + $urandom_range(0, 7)));
                  else
                     line_chars.push_back(bits[24 - k] ? "1" : "0");
                  if (k % 5 == 4) begin
                     line_chars.push_back(" ");
                     add_spaces(1);
                  end
               end
               dec_lines++;
            end
            12, 13: begin
               // 25 random binary digits, mostly bad groups
               for (int k = 0; k < 25; k++) begin
                  line_chars.push_back($urandom_range(0, 1) ? "1" : "0");
                  if (k % 5 == 4)
                     line_chars.push_back(" ");
               end
               dec_lines++;
            end
            14, 15: begin
               // noise: any byte mixed with digits and spaces
               repeat ($urandom_range(1, 12)) begin
                  case ($urandom_range(0, 2))
                     0:       add_digits(1);
                     1:       line_chars.push_back(" ");
                     default: line_chars.push_back(8'($urandom_range(0, 255)));
                  endcase
               end
               other_lines++;
            end
            16, 17, 18: begin
               // wrong digit totals, up past the counter's saturation
               runs = $urandom_range(0, 7);
               if (runs == 1 || runs == 5)
                  runs++;
               repeat (runs) begin
                  add_digits(($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 5);
                  line_chars.push_back(" ");
               end
               other_lines++;
            end
            default: begin
               // empty or spaces only
               add_spaces(3);
               other_lines++;
            end
         endcase
         send_line();
         if ($urandom_range(0, 19) == 0)
            drain_results();
      end

      drain_results();
      repeat (10) @(posedge clock);

      $display("Sent %0d items in %0d lines, %0d line results checked.",
               items_sent, enc_lines + dec_lines + other_lines, lines_checked);
      $display("Lines: %0d five-digit encode, %0d 25-digit decode, %0d malformed or empty.",
               enc_lines, dec_lines, other_lines);
      if (fail_count == 0 && pending_lines == 0) begin
         $display("[two_of_five_code_line_codec] OK");
      end else begin
         $display("[two_of_five_code_line_codec] ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tofc_pkg.sv
rtl/tofc_front.sv
rtl/tofc_queue.sv
rtl/tofc_back.sv
rtl/two_of_five_code_line_codec.sv
rtl/tofc_checker.sv
sim/two_of_five_code_line_codec_checker.sv
sim/two_of_five_code_line_codec_tb.sv
